@@ src/acm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// acm_pkg
// shared types and constants of the audio channel mixer
// ----------------------------------------------------------------------------
package acm_pkg;

    localparam int GAIN_BITS     = 16;
    localparam int CHAN_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEST_CHANNELS   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_ENABLE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_FIRST      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_SECOND     = 3'd4;

    localparam logic [CHAN_BITS-1:0] CHAN_MONO   = 2'd1;
    localparam logic [CHAN_BITS-1:0] CHAN_STEREO = 2'd2;

    typedef struct packed {
        logic [CHAN_BITS-1:0] source_channels;
        logic [CHAN_BITS-1:0] dest_channels;
        logic                 gain_enable;
        logic [GAIN_BITS-1:0] gain_first;
        logic [GAIN_BITS-1:0] gain_second;
    } acm_cfg_t;

endpackage
`default_nettype wire

@@ src/acm_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// acm_cfg_regs
// configuration register file, one register written per beat
// ----------------------------------------------------------------------------
module acm_cfg_regs
    import acm_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 12
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_valid,
    input  wire                      cfg_ready,
    input  wire [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  cfg_data,
    output acm_cfg_t                 cfg
);

    localparam logic [GAIN_BITS-1:0] GainReset = GAIN_BITS'(64'd1 << GAIN_FRAC_BITS);

    acm_cfg_t cfg_reg;
    acm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_CHANNELS: cfg_next.source_channels = cfg_data[CHAN_BITS-1:0];
                REG_DEST_CHANNELS:   cfg_next.dest_channels   = cfg_data[CHAN_BITS-1:0];
                REG_GAIN_ENABLE:     cfg_next.gain_enable     = cfg_data[0];
                REG_GAIN_FIRST:      cfg_next.gain_first      = cfg_data[GAIN_BITS-1:0];
                REG_GAIN_SECOND:     cfg_next.gain_second     = cfg_data[GAIN_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_channels <= CHAN_STEREO;
            cfg_reg.dest_channels   <= CHAN_STEREO;
            cfg_reg.gain_enable     <= 1'b0;
            cfg_reg.gain_first      <= GainReset;
            cfg_reg.gain_second     <= GainReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ src/acm_gain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// acm_gain
// one channel: optional q-format gain with truncation, halving, saturation
// ----------------------------------------------------------------------------
module acm_gain
    import acm_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 12
)
(
    input  wire signed [SAMPLE_BITS:0]   x,
    input  wire        [GAIN_BITS-1:0]   gain,
    input  wire                          gain_enable,
    input  wire                          halve,
    output logic signed [SAMPLE_BITS-1:0] y
);

    localparam int XW = SAMPLE_BITS + 1;
    localparam int PW = XW + GAIN_BITS + 1;

    logic signed [PW-1:0] product;
    logic signed [PW-1:0] biased;
    logic signed [PW-1:0] scaled;
    logic signed [PW-1:0] halved;
    logic signed [PW-1:0] sat_max;
    logic signed [PW-1:0] sat_min;

    always_comb
    begin
        sat_max = PW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        sat_min = ~sat_max;
        product = PW'(x) * PW'($signed({1'b0, gain}));
        // bias negative products so the shift truncates toward zero
        biased  = product + (product[PW-1] ? PW'({GAIN_FRAC_BITS{1'b1}}) : PW'(0));
        scaled  = gain_enable ? (biased >>> GAIN_FRAC_BITS) : PW'(x);
        halved  = halve ? (scaled >>> 1) : scaled;
        if (halved > sat_max)
            y = sat_max[SAMPLE_BITS-1:0];
        else if (halved < sat_min)
            y = sat_min[SAMPLE_BITS-1:0];
        else
            y = halved[SAMPLE_BITS-1:0];
    end

endmodule
`default_nettype wire

@@ src/audio_channel_mixer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// audio_channel_mixer_top
// mono/stereo channel mixer with per-channel gain and saturation
// ----------------------------------------------------------------------------
// One frame is taken on every cycle with start high; busy is never raised.
// Each frame gives exactly one result, shown on out_first/out_second with
// done high for a single cycle once the frame has passed one input
// register, then the channel mix, gain multiply and clamp, then the
// result register. The receiver must take every result as it appears.
// Configuration writes (cfg_ready always high) should only be made while
// no frame is in flight.
module audio_channel_mixer_top
    import acm_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 12
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire signed [SAMPLE_BITS-1:0]  sample_first,
    input  wire signed [SAMPLE_BITS-1:0]  sample_second,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] out_first,
    output logic signed [SAMPLE_BITS-1:0] out_second,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [CFG_IDX_BITS-1:0]        cfg_index,
    input  wire [CFG_DATA_BITS-1:0]       cfg_data
);

    acm_cfg_t cfg;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SAMPLE_BITS-1:0] b_reg;

    logic                          done_reg;
    logic signed [SAMPLE_BITS-1:0] out_first_reg;
    logic signed [SAMPLE_BITS-1:0] out_second_reg;
    logic signed [SAMPLE_BITS-1:0] out_first_next;
    logic signed [SAMPLE_BITS-1:0] out_second_next;

    logic                          src_mono;
    logic                          dst_mono;
    logic                          downmix;
    logic signed [SAMPLE_BITS:0]   x_first;
    logic signed [SAMPLE_BITS:0]   x_second;
    logic signed [SAMPLE_BITS-1:0] y_first;
    logic signed [SAMPLE_BITS-1:0] y_second;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    acm_cfg_regs #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            a_reg <= sample_first;
            b_reg <= sample_second;
        end
    end

    // channel routing
    always_comb
    begin
        src_mono = (cfg.source_channels == CHAN_MONO);
        dst_mono = (cfg.dest_channels == CHAN_MONO);
        downmix  = dst_mono && !src_mono;
        x_first  = downmix ? ((SAMPLE_BITS+1)'(a_reg) + (SAMPLE_BITS+1)'(b_reg))
                           : (SAMPLE_BITS+1)'(a_reg);
        x_second = src_mono ? (SAMPLE_BITS+1)'(a_reg) : (SAMPLE_BITS+1)'(b_reg);
    end

    acm_gain #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain_first (
        .x           (x_first),
        .gain        (cfg.gain_first),
        .gain_enable (cfg.gain_enable),
        .halve       (downmix),
        .y           (y_first)
    );

    acm_gain #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain_second (
        .x           (x_second),
        .gain        (cfg.gain_second),
        .gain_enable (cfg.gain_enable),
        .halve       (1'b0),
        .y           (y_second)
    );

    assign out_first_next  = y_first;
    assign out_second_next = dst_mono ? '0 : y_second;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
        end
    end

    assign done       = done_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;

endmodule
`default_nettype wire

@@ tb/audio_channel_mixer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_channel_mixer_top_tb
// self-checking testbench for the mono/stereo channel mixer
// ----------------------------------------------------------------------------
// Frames are sent with random idle gaps and every result frame is compared
// against an in-bench model of the channel mix, Q4.12 gain and clamp. The
// configuration registers are changed only while no frame is in flight,
// stepping through all channel modes, odd channel counts and gain extremes,
// followed by randomised phases of frames.
module audio_channel_mixer_top_tb;

    import acm_pkg::*;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_LIMIT    = 1000;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_FRAMES  = 1650;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] first;
        logic signed [SAMPLE_BITS-1:0] second;
    } frame_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] sample_first;
    logic signed [SAMPLE_BITS-1:0] sample_second;
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] out_first;
    logic signed [SAMPLE_BITS-1:0] out_second;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;

    acm_cfg_t mix_cfg;
    frame_t   mixed_frames_due[$];
    int       failures;
    int       frames_sent;
    int       frames_checked;
    int       settings_applied;

    audio_channel_mixer_top #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample_first  (sample_first),
        .sample_second (sample_second),
        .done          (done),
        .out_first     (out_first),
        .out_second    (out_second),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint scale_q412(input longint x, input logic [GAIN_BITS-1:0] g);
        longint gl;
        longint p;
        gl = longint'(g);
        p  = x * gl;
        if (p >= 0)
            return p >>> GAIN_FRAC_BITS;
        return -((-p) >>> GAIN_FRAC_BITS);
    endfunction

    function automatic longint clamp_sample(input longint x);
        if (x > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (x < SAMPLE_MIN)
            return SAMPLE_MIN;
        return x;
    endfunction

    function automatic frame_t mix_frame(input logic signed [SAMPLE_BITS-1:0] a,
                                         input logic signed [SAMPLE_BITS-1:0] b);
        frame_t r;
        longint sa;
        longint sb;
        longint right;
        longint f;
        longint s;
        bit     src_mono;
        bit     dst_mono;
        bit     use_gain;
        sa       = longint'(a);
        sb       = longint'(b);
        s        = 0;
        src_mono = (mix_cfg.source_channels == CHAN_MONO);
        dst_mono = (mix_cfg.dest_channels == CHAN_MONO);
        use_gain = mix_cfg.gain_enable;
        if (dst_mono)
        begin
            if (src_mono)
                f = use_gain ? clamp_sample(scale_q412(sa, mix_cfg.gain_first)) : sa;
            else if (use_gain)
                f = clamp_sample(scale_q412(sa + sb, mix_cfg.gain_first) >>> 1);
            else
                f = (sa + sb) >>> 1;
        end
        else
        begin
            right = src_mono ? sa : sb;
            if (use_gain)
            begin
                f = clamp_sample(scale_q412(sa, mix_cfg.gain_first));
                s = clamp_sample(scale_q412(right, mix_cfg.gain_second));
            end
            else
            begin
                f = sa;
                s = right;
            end
        end
        r.first  = f[SAMPLE_BITS-1:0];
        r.second = s[SAMPLE_BITS-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        frame_t due;
        if (rst_n && done)
        begin
            if (mixed_frames_due.size() == 0)
            begin
                $error("result frame with none expected: out_first %0d, out_second %0d",
                       out_first, out_second);
                failures++;
            end
            else
            begin
                due = mixed_frames_due.pop_front();
                frames_checked++;
                if (out_first !== due.first)
                begin
                    $error("out_first mismatch: expected %0d, got %0d", due.first, out_first);
                    failures++;
                end
                if (out_second !== due.second)
                begin
                    $error("out_second mismatch: expected %0d, got %0d", due.second, out_second);
                    failures++;
                end
            end
        end
    end

    task automatic send_frame(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b,
                              input bit no_idle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        sample_first  <= a;
        sample_second <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mixed_frames_due.push_back(mix_frame(a, b));
        frames_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        int gap;
        start <= 1'b0;
        while (mixed_frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        gap = $urandom_range(0, 17);
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // config beat taken
        case (idx)
            REG_SOURCE_CHANNELS: mix_cfg.source_channels = data[CHAN_BITS-1:0];
            REG_DEST_CHANNELS:   mix_cfg.dest_channels   = data[CHAN_BITS-1:0];
            REG_GAIN_ENABLE:     mix_cfg.gain_enable     = data[0];
            REG_GAIN_FIRST:      mix_cfg.gain_first      = data;
            REG_GAIN_SECOND:     mix_cfg.gain_second     = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic [CFG_DATA_BITS-1:0] src, input logic [CFG_DATA_BITS-1:0] dst,
                            input logic [CFG_DATA_BITS-1:0] en, input logic [GAIN_BITS-1:0] g1,
                            input logic [GAIN_BITS-1:0] g2);
        write_register(REG_SOURCE_CHANNELS, src);
        write_register(REG_DEST_CHANNELS, dst);
        write_register(REG_GAIN_ENABLE, en);
        write_register(REG_GAIN_FIRST, g1);
        write_register(REG_GAIN_SECOND, g2);
        settings_applied++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] draw_gain();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h1000;
            2: return 16'hffff;
            3: return GAIN_BITS'($urandom_range(0, 8192));
            default: return GAIN_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] draw_channels();
        logic [CFG_DATA_BITS-1:0] v;
        v = CFG_DATA_BITS'($urandom());
        case ($urandom_range(0, 7))
            0: v[1:0] = 2'd0;
            1: v[1:0] = 2'd3;
            2, 3, 4: v[1:0] = CHAN_MONO;
            default: v[1:0] = CHAN_STEREO;
        endcase
        if ($urandom_range(0, 1) == 0)
            v[CFG_DATA_BITS-1:2] = '0;
        return v;
    endfunction

    task automatic test_reset_defaults();
        send_frame(16'h7fff, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7fff, 1'b1);
        send_frame(16'h0000, 16'hffff, 1'b0);
    endtask

    task automatic test_channel_modes();
        int s;
        int d;
        for (s = 1; s <= 2; s++)
        begin
            for (d = 1; d <= 2; d++)
            begin
                set_mode(CFG_DATA_BITS'(s), CFG_DATA_BITS'(d), 16'd0, 16'h1000, 16'h1000);
                send_frame(16'h7fff, 16'h7fff, 1'b0);
                send_frame(16'h0001, 16'hfffe, 1'b1);
            end
        end
        send_frame(16'h8000, 16'h8001, 1'b0);
    endtask

    task automatic test_gain_saturation();
        set_mode(CFG_DATA_BITS'(CHAN_STEREO), CFG_DATA_BITS'(CHAN_STEREO), 16'd1,
                 16'hffff, 16'h0000);
        send_frame(16'h7fff, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7fff, 1'b1);
        set_mode(CFG_DATA_BITS'(CHAN_STEREO), CFG_DATA_BITS'(CHAN_MONO), 16'd1,
                 16'hffff, 16'hffff);
        send_frame(16'h8000, 16'h8000, 1'b0);
        send_frame(16'h7fff, 16'h7fff, 1'b0);
        set_mode(CFG_DATA_BITS'(CHAN_MONO), CFG_DATA_BITS'(CHAN_STEREO), 16'd1,
                 16'h0800, 16'hffff);
        send_frame(16'hffff, 16'h1234, 1'b0);
        send_frame(16'h8000, 16'h0000, 1'b1);
    endtask

    task automatic test_odd_channel_counts();
        set_mode(16'd0, 16'd3, 16'd0, 16'h1000, 16'h1000);
        send_frame(16'h8000, 16'h7fff, 1'b0);
        set_mode(16'd3, 16'd0, 16'hfffe, 16'h1000, 16'h1000);
        send_frame(16'h1234, 16'hedcb, 1'b0);
        write_register(REG_DEST_CHANNELS, 16'hfffd);
        write_register(3'd5, 16'hffff);
        write_register(3'd6, 16'h0000);
        write_register(3'd7, 16'hffff);
        send_frame(16'h8001, 16'h8000, 1'b0);
    endtask

    task automatic test_random_phases();
        int  n;
        int  i;
        bit  no_idle;
        int  target;
        target = frames_sent + RANDOM_FRAMES;
        while (frames_sent < target)
        begin
            set_mode(draw_channels(), draw_channels(),
                     {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))}, draw_gain(),
                     draw_gain());
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_IDX_BITS'($urandom_range(5, 7)), CFG_DATA_BITS'($urandom()));
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 80);
            for (i = 0; i < n; i++)
                send_frame(draw_sample(), draw_sample(), no_idle);
        end
    endtask

    initial
    begin
        int drain;
        failures         = 0;
        frames_sent      = 0;
        frames_checked   = 0;
        settings_applied = 0;
        mix_cfg.source_channels = CHAN_STEREO;
        mix_cfg.dest_channels   = CHAN_STEREO;
        mix_cfg.gain_enable     = 1'b0;
        mix_cfg.gain_first      = 16'h1000;
        mix_cfg.gain_second     = 16'h1000;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        sample_first  <= '0;
        sample_second <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_channel_modes();
        test_gain_saturation();
        test_odd_channel_counts();
        test_random_phases();

        start <= 1'b0;
        drain = 0;
        while (mixed_frames_due.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mixed_frames_due.size() != 0)
        begin
            $error("%0d result frames never arrived", mixed_frames_due.size());
            failures++;
        end

        $display("%0d frames sent, %0d result frames checked over %0d register settings",
                 frames_sent, frames_checked, settings_applied);
        $display("covered: all mix modes, odd channel counts, gain extremes, idle gaps");
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ audio_channel_mixer_top.f @@
src/acm_pkg.sv
src/acm_cfg_regs.sv
src/acm_gain.sv
src/audio_channel_mixer_top.sv
tb/audio_channel_mixer_top_tb.sv
